// ----- rtl/twr_pkg.sv -----
// twr_pkg: shared types and constants for the texture twiddle reorder block
// used by twr_addr and texture_twiddle_reorder; depends on nothing
`default_nettype none

package twr_pkg;

	localparam int MAX_LOG2_SIDE = 6;
	localparam int ADDR_W        = 2 * MAX_LOG2_SIDE;
	localparam int CNT_W         = ADDR_W + 1;
	localparam int DEPTH         = 1 << ADDR_W;
	localparam int TEXEL_W       = 16;
	localparam int LOG_W         = 3;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_FETCH = 1'b1;

	localparam logic REG_LOG2_WIDTH  = 1'b0;
	localparam logic REG_LOG2_HEIGHT = 1'b1;

	// clamped texture geometry handed to the address unit
	typedef struct packed {
		logic [LOG_W-1:0] lw;
		logic [LOG_W-1:0] lh;
	} twr_geom_t;

endpackage

`default_nettype wire

// ----- rtl/texture_twiddle_reorder.sv -----
// texture_twiddle_reorder: top level with texel store, counters and result register
// depends on twr_pkg and twr_addr
`default_nettype none

// Takes one word per cycle on the request channel while req_ready is high. A write
// word (kind 0) stores the next texel in raster order; once width*height texels
// have arrived the texture is ready. A fetch word (kind 1) yields one result word:
// the next texel in twiddled order, with last set on the final one, after which the
// sequence rewinds. A fetch before a complete load gives texel 0 with empty_res set.
// A write after a complete load starts a new load. Writing either size register
// clears the load and fetch position; sizes above 64 texels are taken as 64.
// Throughput is one word per cycle unless results stall; a fetch result passes the
// registered read of the single 4096-entry texel memory and the output register.
module texture_twiddle_reorder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [twr_pkg::LOG_W-1:0]   cfg_data,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic                        kind,
	input  wire logic [twr_pkg::TEXEL_W-1:0] texel_in,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [twr_pkg::TEXEL_W-1:0]      texel_out,
	output logic                             last,
	output logic                             empty_res
);
	import twr_pkg::*;

	logic [LOG_W-1:0]   log2_width_q;
	logic [LOG_W-1:0]   log2_height_q;
	logic [CNT_W-1:0]   load_cnt_q;
	logic [ADDR_W-1:0]  emit_cnt_q;
	logic               ready_q;

	logic [TEXEL_W-1:0] mem [0:DEPTH-1];
	logic [TEXEL_W-1:0] rd_data_s1;
	logic               valid_s1;
	logic               last_s1;
	logic               empty_s1;

	twr_geom_t          geom;
	logic [CNT_W-1:0]   total;
	logic [ADDR_W-1:0]  rd_addr;
	logic               advance;
	logic               accept;
	logic               wr_en;
	logic               rd_en;
	logic [CNT_W-1:0]   load_base;
	logic [CNT_W-1:0]   load_next;
	logic [CNT_W-1:0]   emit_next;
	logic               emit_last;

	assign geom.lw = (log2_width_q > LOG_W'(MAX_LOG2_SIDE)) ?
		LOG_W'(MAX_LOG2_SIDE) : log2_width_q;
	assign geom.lh = (log2_height_q > LOG_W'(MAX_LOG2_SIDE)) ?
		LOG_W'(MAX_LOG2_SIDE) : log2_height_q;
	assign total = CNT_W'(1) << (CNT_W'(geom.lw) + CNT_W'(geom.lh));

	twr_addr u_addr (
		.geom (geom),
		.idx  (emit_cnt_q),
		.addr (rd_addr)
	);

	assign advance   = !res_valid || res_ready;
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;
	assign wr_en     = accept && (kind == KIND_WRITE);
	assign rd_en     = accept && (kind == KIND_FETCH) && ready_q;

	// a write after a complete load restarts at raster position zero
	assign load_base = ready_q ? '0 : load_cnt_q;
	assign load_next = load_base + CNT_W'(1);
	assign emit_next = CNT_W'(emit_cnt_q) + CNT_W'(1);
	assign emit_last = emit_next >= total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_width_q  <= LOG_W'(3);
			log2_height_q <= LOG_W'(3);
			load_cnt_q    <= '0;
			emit_cnt_q    <= '0;
			ready_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOG2_WIDTH:  log2_width_q  <= cfg_data;
				REG_LOG2_HEIGHT: log2_height_q <= cfg_data;
				default:         log2_width_q  <= log2_width_q;
			endcase
			load_cnt_q <= '0;
			emit_cnt_q <= '0;
			ready_q    <= 1'b0;
		end else if (wr_en) begin
			load_cnt_q <= load_next;
			emit_cnt_q <= '0;
			ready_q    <= load_next >= total;
		end else if (rd_en) begin
			emit_cnt_q <= emit_last ? '0 : emit_next[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[load_base[ADDR_W-1:0]] <= texel_in;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			empty_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= accept && (kind == KIND_FETCH);
			last_s1  <= ready_q && emit_last;
			empty_s1 <= !ready_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			texel_out <= '0;
			last      <= 1'b0;
			empty_res <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
			texel_out <= empty_s1 ? '0 : rd_data_s1;
			last      <= last_s1;
			empty_res <= empty_s1;
		end
	end

`ifndef SYNTHESIS
	a_empty_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && empty_res |-> !last && texel_out == '0)
		else $error("empty result carries texel or last");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> load_cnt_q == total)
		else $error("texture ready with incomplete load count");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ready_q |-> emit_cnt_q == '0)
		else $error("fetch position moved without a loaded texture");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> CNT_W'(emit_cnt_q) < total)
		else $error("fetch position beyond texture");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid && !res_ready |-> !req_ready)
		else $error("request taken while read stage is stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/twr_addr.sv -----
// twr_addr: maps a twiddled (morton) index to a raster store address
// depends on twr_pkg
`default_nettype none

module twr_addr (
	input  var twr_pkg::twr_geom_t          geom,
	input  wire logic [twr_pkg::ADDR_W-1:0] idx,
	output logic [twr_pkg::ADDR_W-1:0]      addr
);
	import twr_pkg::*;

	logic [LOG_W-1:0]  side;
	logic [ADDR_W-1:0] xs;
	logic [ADDR_W-1:0] ys;
	logic [ADDR_W-1:0] sq;
	logic [ADDR_W-1:0] sq_sh;

	assign side = (geom.lw < geom.lh) ? geom.lw : geom.lh;

	always_comb begin
		xs = '0;
		ys = '0;
		for (int i = 0; i < MAX_LOG2_SIDE; i++) begin
			if (i < int'(side)) begin
				ys[i] = idx[2*i];
				xs[i] = idx[2*i+1];
			end
		end
	end

	// index bits above the square select which square, along the longer side
	assign sq    = idx >> {side, 1'b0};
	assign sq_sh = sq << side;

	always_comb begin
		if (geom.lw > geom.lh) begin
			addr = (xs | sq_sh) | (ys << geom.lw);
		end else begin
			addr = xs | ((ys | sq_sh) << geom.lw);
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/tb_texture_twiddle_reorder.sv -----
// tb_texture_twiddle_reorder: self-checking bench for texture_twiddle_reorder
// loads textures in raster order and checks fetched texels against a twiddle-order predictor
// depends on twr_pkg and the texture_twiddle_reorder rtl
`timescale 1ns / 100ps

typedef struct packed {
	logic [twr_pkg::TEXEL_W-1:0] texel;
	logic                        last_flag;
	logic                        empty_flag;
} texel_result_t;

class twiddle_scoreboard;
	logic [twr_pkg::TEXEL_W-1:0] store [twr_pkg::DEPTH];
	logic [twr_pkg::CNT_W-1:0]   loaded;
	logic [twr_pkg::ADDR_W-1:0]  fetch_pos;
	bit                          ready;
	logic [twr_pkg::LOG_W-1:0]   width_log;
	logic [twr_pkg::LOG_W-1:0]   height_log;
	texel_result_t               expected_texels [$];
	int                          errors;

	function new();
		foreach (store[i]) store[i] = '0;
		loaded     = '0;
		fetch_pos  = '0;
		ready      = 1'b0;
		width_log  = 3'd3;
		height_log = 3'd3;
		errors     = 0;
	endfunction

	function int clamp_log(logic [twr_pkg::LOG_W-1:0] v);
		return (v > twr_pkg::MAX_LOG2_SIDE) ? twr_pkg::MAX_LOG2_SIDE : int'(v);
	endfunction

	function int texel_count();
		return 1 << (clamp_log(width_log) + clamp_log(height_log));
	endfunction

	// raster position of twiddled index idx
	function int raster_index(int idx);
		int lw, lh, s, x, y, sq;
		lw = clamp_log(width_log);
		lh = clamp_log(height_log);
		s  = (lw < lh) ? lw : lh;
		x  = 0;
		y  = 0;
		for (int i = 0; i < s; i++) begin
			y |= ((idx >> (2 * i)) & 1) << i;
			x |= ((idx >> (2 * i + 1)) & 1) << i;
		end
		sq = idx >> (2 * s);
		if (lw > lh) begin
			x += sq << s;
		end else begin
			y += sq << s;
		end
		return (x + (y << lw)) & (twr_pkg::DEPTH - 1);
	endfunction

	function int pending();
		return expected_texels.size();
	endfunction

	// any size write drops the load and fetch position, the store is kept
	function void write_size(logic idx, logic [twr_pkg::LOG_W-1:0] v);
		if (idx == twr_pkg::REG_LOG2_WIDTH) begin
			width_log = v;
		end else begin
			height_log = v;
		end
		loaded    = '0;
		fetch_pos = '0;
		ready     = 1'b0;
	endfunction

	function void note_word(logic k, logic [twr_pkg::TEXEL_W-1:0] t);
		int total;
		texel_result_t r;
		total = texel_count();
		if (k == twr_pkg::KIND_WRITE) begin
			// a write after a finished load starts a fresh one
			if (ready) begin
				ready     = 1'b0;
				loaded    = '0;
				fetch_pos = '0;
			end
			store[loaded[twr_pkg::ADDR_W-1:0]] = t;
			loaded++;
			if (int'(loaded) >= total) begin
				ready     = 1'b1;
				fetch_pos = '0;
			end
		end else if (!ready) begin
			r.texel      = '0;
			r.last_flag  = 1'b0;
			r.empty_flag = 1'b1;
			expected_texels.push_back(r);
		end else begin
			r.texel      = store[raster_index(int'(fetch_pos))];
			r.empty_flag = 1'b0;
			if (int'(fetch_pos) + 1 >= total) begin
				r.last_flag = 1'b1;
				fetch_pos   = '0;
			end else begin
				r.last_flag = 1'b0;
				fetch_pos++;
			end
			expected_texels.push_back(r);
		end
	endfunction

	task report(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch: %s got %0h want %0h", what, got, want);
		errors++;
	endtask

	task check_result(logic [twr_pkg::TEXEL_W-1:0] t, logic lst, logic emp);
		texel_result_t w;
		if (expected_texels.size() == 0) begin
			report("unexpected word, texel", t, '0);
		end else begin
			w = expected_texels.pop_front();
			if (t !== w.texel) report("texel_out", t, w.texel);
			if (lst !== w.last_flag) report("last", lst, w.last_flag);
			if (emp !== w.empty_flag) report("empty_res", emp, w.empty_flag);
		end
	endtask
endclass

module tb_texture_twiddle_reorder;
	import twr_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_WORDS  = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [LOG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	logic                 kind;
	logic [TEXEL_W-1:0]   texel_in;
	logic                 res_valid;
	logic                 res_ready;
	logic [TEXEL_W-1:0]   texel_out;
	logic                 last;
	logic                 empty_res;

	twiddle_scoreboard sb;
	int  burst_left;
	int  words_taken;
	int  idle_cycles;
	bit  squeeze;

	texture_twiddle_reorder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.kind      (kind),
		.texel_in  (texel_in),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.texel_out (texel_out),
		.last      (last),
		.empty_res (empty_res)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [TEXEL_W-1:0] rand_texel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up across back-to-back words
	task automatic send_word(input logic k, input logic [TEXEL_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 150);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				req_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_valid = 1'b1;
		kind      = k;
		texel_in  = t;
		do @(posedge clk); while (!req_ready);
		sb.note_word(k, t);
		burst_left--;
		words_taken++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [LOG_W-1:0] v);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(posedge clk);
		sb.write_size(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// sizes only change once the block has drained
	task automatic set_size(input logic [LOG_W-1:0] w, input logic [LOG_W-1:0] h);
		req_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_LOG2_WIDTH, w);
			write_reg(REG_LOG2_HEIGHT, h);
		end else begin
			write_reg(REG_LOG2_HEIGHT, h);
			write_reg(REG_LOG2_WIDTH, w);
		end
	endtask

	task automatic texture_phase(input logic [LOG_W-1:0] w, input logic [LOG_W-1:0] h,
				     input int rounds, input int max_fetch, input bit hold_results);
		int total, cap, nf;
		set_size(w, h);
		total = 1 << (((w > MAX_LOG2_SIDE) ? MAX_LOG2_SIDE : int'(w)) +
			      ((h > MAX_LOG2_SIDE) ? MAX_LOG2_SIDE : int'(h)));
		cap = (2 * total + 2 < max_fetch) ? 2 * total + 2 : max_fetch;
		for (int r = 0; r < rounds; r++) begin
			if ($urandom_range(0, 3) == 0) send_word(KIND_FETCH, rand_texel());
			for (int n = 0; n < total; n++) begin
				// stray fetch among the writes comes back empty once this load has begun
				if ($urandom_range(0, 24) == 0) send_word(KIND_FETCH, rand_texel());
				send_word(KIND_WRITE, rand_texel());
			end
			if (hold_results && r == 0) begin
				squeeze = 1'b1;
				nf = cap;
			end else begin
				nf = $urandom_range(1, cap);
			end
			repeat (nf) send_word(KIND_FETCH, rand_texel());
		end
		// broken sequence: a load cut short by the next size write
		if (total > 1 && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, total - 1)) send_word(KIND_WRITE, rand_texel());
		end
	endtask

	initial begin
		logic [LOG_W-1:0] a, b, c;
		int ca;
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_LOG2_WIDTH;
		cfg_data    = '0;
		req_valid   = 1'b0;
		kind        = KIND_WRITE;
		texel_in    = '0;
		burst_left  = 0;
		words_taken = 0;
		squeeze     = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single texel: empty fetch, load, rewind, reload
		set_size(3'd0, 3'd0);
		send_word(KIND_FETCH, 16'hFFFF);
		send_word(KIND_WRITE, 16'hFFFF);
		send_word(KIND_FETCH, 16'h0000);
		send_word(KIND_FETCH, 16'h0000);
		send_word(KIND_WRITE, 16'h0000);
		send_word(KIND_FETCH, 16'hFFFF);
		// wide and tall two-texel cases, then a square four-texel case
		set_size(3'd1, 3'd0);
		send_word(KIND_WRITE, 16'hFFFF);
		send_word(KIND_WRITE, 16'h0001);
		send_word(KIND_FETCH, 16'h0000);
		send_word(KIND_FETCH, 16'h0000);
		set_size(3'd0, 3'd1);
		send_word(KIND_WRITE, 16'h8000);
		send_word(KIND_WRITE, 16'h7FFF);
		send_word(KIND_FETCH, 16'h0000);
		send_word(KIND_FETCH, 16'h0000);
		set_size(3'd1, 3'd1);
		send_word(KIND_WRITE, 16'h1111);
		send_word(KIND_WRITE, 16'h2222);
		send_word(KIND_WRITE, 16'h4444);
		send_word(KIND_WRITE, 16'h8888);
		repeat (4) send_word(KIND_FETCH, 16'h5555);

		// clamped and extreme shapes, with the long receiver hold-off in the 4x4 phase
		texture_phase(3'd7, 3'd0, 1, 200, 1'b0);
		texture_phase(3'd0, 3'd7, 1, 200, 1'b0);
		texture_phase(3'd6, 3'd1, 1, 100, 1'b0);
		texture_phase(3'd1, 3'd6, 1, 100, 1'b0);
		texture_phase(3'd2, 3'd2, 1, 80, 1'b1);
		texture_phase(3'd7, 3'd2, 1, 300, 1'b0);

		words_taken = 0;
		while (words_taken < RANDOM_WORDS) begin
			a  = 3'($urandom_range(0, 7));
			ca = (a > MAX_LOG2_SIDE) ? MAX_LOG2_SIDE : int'(a);
			b  = 3'($urandom_range(0, 6 - ca));
			if ($urandom_range(0, 1) == 0) begin
				c = a;
				a = b;
				b = c;
			end
			texture_phase(a, b, $urandom_range(1, 3), 160, 1'b0);
		end

		req_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side: stall pattern of its own, plus one long hold-off on request
	initial begin
		int mode, stretch, tick;
		res_ready = 1'b0;
		mode      = 0;
		stretch   = 0;
		tick      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				squeeze = 1'b0;
			end
			if (stretch == 0) begin
				mode    = $urandom_range(0, 3);
				stretch = $urandom_range(16, 80);
			end
			stretch--;
			tick++;
			case (mode)
				0: res_ready = 1'b1;
				1: res_ready = 1'($urandom_range(0, 1));
				2: res_ready = (tick % 4 == 0);
				default: res_ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) sb.check_result(texel_out, last, empty_res);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule
